/* rtl/fault_code_record_table_core_assert.svh */
// assertion macros shared by the fault record table checker
// no dependencies; include by bare file name inside a module body
`ifndef FAULT_CODE_RECORD_TABLE_CORE_ASSERT_SVH
`define FAULT_CODE_RECORD_TABLE_CORE_ASSERT_SVH

// concurrent assertion on an explicit clock and active-low reset
`define FCRT_ASSERT_CLK(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
    else $error("fcrt assertion failed");

// concurrent assertion on clk_i and rst_ni
`define FCRT_ASSERT(name, prop) \
  `FCRT_ASSERT_CLK(name, clk_i, rst_ni, prop)

`endif

/* rtl/fcrt_pkg.sv */
// shared types, constants and field layout for the fault record table
// no dependencies; imported by every module of the block except fcrt_ram
`default_nettype none

package fcrt_pkg;

  localparam int unsigned NUM_CODES  = 16;
  localparam int unsigned COUNT_BITS = 32;
  localparam int unsigned CODE_BITS  = 4;
  localparam int unsigned TIME_BITS  = 64;
  localparam int unsigned OCC_BITS   = 32;

  // codes are 4 bits wide, so at most 16 records can ever be addressed
  localparam int unsigned TABLE_DEPTH =
    (NUM_CODES < (2 ** CODE_BITS)) ? NUM_CODES : (2 ** CODE_BITS);
  localparam int unsigned IDX_BITS = $clog2(TABLE_DEPTH);

  // record word in memory: {last, first, count}
  localparam int unsigned REC_BITS = COUNT_BITS + 2 * TIME_BITS;

  // stream layout
  localparam int unsigned S_TDATA_BITS = 72;
  localparam int unsigned S_TUSER_BITS = 2;
  localparam int unsigned M_TDATA_BITS = 168;

  localparam int unsigned OUT_CODE_LSB   = 0;
  localparam int unsigned OUT_STATUS_LSB = OUT_CODE_LSB + CODE_BITS;
  localparam int unsigned OUT_COUNT_LSB  = OUT_STATUS_LSB + 2;
  localparam int unsigned OUT_FIRST_LSB  = OUT_COUNT_LSB + OCC_BITS;
  localparam int unsigned OUT_LAST_LSB   = OUT_FIRST_LSB + TIME_BITS;
  localparam int unsigned OUT_REQ_BIT    = OUT_LAST_LSB + TIME_BITS;
  localparam int unsigned OUT_ACT_BIT    = OUT_REQ_BIT + 1;

  // configuration
  localparam int unsigned CFG_IDX_BITS  = 1;
  localparam int unsigned CFG_DATA_BITS = 16;
  localparam logic [15:0] FATAL_MASK_RST = 16'h0C40;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_FATAL_MASK = 1'b0,
    CFG_SAFE_EN    = 1'b1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    KIND_REPORT = 2'd0,
    KIND_HEAL   = 2'd1,
    KIND_CLEAR  = 2'd2,
    KIND_READ   = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    STAT_ABSENT = 2'd0,
    STAT_ACTIVE = 2'd1,
    STAT_HEALED = 2'd2
  } status_e;

  typedef enum logic {
    FSM_IDLE   = 1'b0,
    FSM_UPDATE = 1'b1
  } fsm_e;

  // status table update command
  typedef struct packed {
    logic                wr;
    logic [IDX_BITS-1:0] idx;
    status_e             status;
    logic                clear_healed;
  } status_cmd_t;

endpackage

`default_nettype wire

/* rtl/fault_code_record_table_core.sv */
// top level of the fault record table: stream ports, sequencer, record update
// depends on fcrt_pkg, fcrt_ram and fcrt_status
`default_nettype none

// Fault record table. One record per fault code (status, saturating count,
// first and last timestamp). The accept cycle issues the record read from
// the record memory, which registers its read data; the update state then
// modifies the record and writes it back while the result is loaded into the
// output register. A new item is taken only once the last one is written
// back; a stalled output holds the update state. Status sits in flops so
// that a clear drops all healed records at once; absent records read as
// zeros, so the memory needs no clearing pass after reset.
module fault_code_record_table_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // slave stream: tdata fields from bit 0: fault_code, time_us, zero pad
  //   tuser fields from bit 0: kind
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [fcrt_pkg::S_TDATA_BITS-1:0]   s_axis_tdata,
  input  logic [fcrt_pkg::S_TUSER_BITS-1:0]   s_axis_tuser,
  // master stream: tdata fields from bit 0: code_echo, record_status,
  //   occur_count, first_time_us, last_time_us, safe_state_request, any_active
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [fcrt_pkg::M_TDATA_BITS-1:0]   m_axis_tdata,
  // configuration write port
  input  logic                                cfg_we_i,
  input  logic [fcrt_pkg::CFG_IDX_BITS-1:0]   cfg_idx_i,
  input  logic [fcrt_pkg::CFG_DATA_BITS-1:0]  cfg_wdata_i
);
  import fcrt_pkg::*;

  fsm_e state_q, state_d;

  logic [15:0] fatal_mask_q;
  logic        safe_en_q;

  kind_e                kind_q;
  logic [CODE_BITS-1:0] code_q;
  logic [TIME_BITS-1:0] time_q;

  logic                 out_valid_q;
  logic [CODE_BITS-1:0] out_code_q;
  status_e              out_status_q;
  logic [OCC_BITS-1:0]  out_count_q;
  logic [TIME_BITS-1:0] out_first_q, out_last_q;
  logic                 out_req_q, out_act_q;

  logic                 accept, fire;
  logic [CODE_BITS-1:0] s_code;
  logic [REC_BITS-1:0]  rec_rd, rec_wr;
  logic                 ram_we;

  logic [COUNT_BITS-1:0] cur_count, new_count;
  logic [TIME_BITS-1:0]  cur_first, cur_last, new_first, new_last;
  status_e               cur_status, new_status;
  logic                  code_ok, req;
  logic                  any_active_next;
  status_cmd_t           scmd;

  assign s_code = s_axis_tdata[CODE_BITS-1:0];
  assign accept = s_axis_tvalid && s_axis_tready;

  // sequencer
  always_comb begin
    state_d       = state_q;
    s_axis_tready = 1'b0;
    fire          = 1'b0;
    unique case (state_q)
      FSM_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          state_d = FSM_UPDATE;
        end
      end
      FSM_UPDATE: begin
        // write back only when the output register can take the result
        if (!out_valid_q || m_axis_tready) begin
          fire    = 1'b1;
          state_d = FSM_IDLE;
        end
      end
      default: state_d = FSM_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FSM_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fatal_mask_q <= FATAL_MASK_RST;
      safe_en_q    <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_FATAL_MASK: fatal_mask_q <= cfg_wdata_i[15:0];
        CFG_SAFE_EN:    safe_en_q    <= cfg_wdata_i[0];
        default:        ;
      endcase
    end
  end

  // item registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q <= kind_e'(s_axis_tuser);
      code_q <= s_code;
      time_q <= s_axis_tdata[CODE_BITS +: TIME_BITS];
    end
  end

  fcrt_ram #(
    .WIDTH (REC_BITS),
    .DEPTH (TABLE_DEPTH)
  ) u_fcrt_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (code_q[IDX_BITS-1:0]),
    .wdata_i (rec_wr),
    .re_i    (accept),
    .raddr_i (s_code[IDX_BITS-1:0]),
    .rdata_o (rec_rd)
  );

  fcrt_status u_fcrt_status (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (scmd),
    .rd_idx_i          (code_q[IDX_BITS-1:0]),
    .rd_status_o       (cur_status),
    .any_active_next_o (any_active_next)
  );

  assign code_ok   = ({1'b0, code_q} < (CODE_BITS + 1)'(TABLE_DEPTH));
  assign cur_count = rec_rd[COUNT_BITS-1:0];
  assign cur_first = rec_rd[COUNT_BITS +: TIME_BITS];
  assign cur_last  = rec_rd[COUNT_BITS + TIME_BITS +: TIME_BITS];
  assign rec_wr    = {new_last, new_first, new_count};

  // record modify
  always_comb begin
    new_status        = cur_status;
    new_count         = cur_count;
    new_first         = cur_first;
    new_last          = cur_last;
    req               = 1'b0;
    ram_we            = 1'b0;
    scmd.wr           = 1'b0;
    scmd.idx          = code_q[IDX_BITS-1:0];
    scmd.status       = cur_status;
    scmd.clear_healed = 1'b0;
    unique case (kind_q)
      KIND_REPORT: begin
        if (code_ok) begin
          if (cur_status == STAT_ABSENT) begin
            new_count = COUNT_BITS'(1);
            new_first = time_q;
          end else if (cur_count != {COUNT_BITS{1'b1}}) begin
            new_count = cur_count + COUNT_BITS'(1);
          end
          new_status = STAT_ACTIVE;
          new_last   = time_q;
          req        = fatal_mask_q[code_q] & safe_en_q;
          ram_we     = fire;
          scmd.wr    = fire;
        end
      end
      KIND_HEAL: begin
        if (code_ok && cur_status == STAT_ACTIVE) begin
          new_status = STAT_HEALED;
          scmd.wr    = fire;
        end
      end
      KIND_CLEAR: begin
        if (cur_status != STAT_ACTIVE) begin
          new_status = STAT_ABSENT;
        end
        scmd.clear_healed = fire;
      end
      KIND_READ: ;
      default:   ;
    endcase
    scmd.status = new_status;
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_code_q <= code_q;
      out_req_q  <= req;
      out_act_q  <= any_active_next;
      // absent or out-of-range records read as all zeros
      if (!code_ok || new_status == STAT_ABSENT) begin
        out_status_q <= STAT_ABSENT;
        out_count_q  <= '0;
        out_first_q  <= '0;
        out_last_q   <= '0;
      end else begin
        out_status_q <= new_status;
        out_count_q  <= OCC_BITS'(new_count);
        out_first_q  <= new_first;
        out_last_q   <= new_last;
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_act_q, out_req_q, out_last_q, out_first_q,
                          out_count_q, out_status_q, out_code_q};

endmodule

`default_nettype wire

/* rtl/fcrt_ram.sv */
// generic single-port-write, single-port-read ram with registered read data
// no dependencies
`default_nettype none

module fcrt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    // read data holds until the next read
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* rtl/fcrt_status.sv */
// per-code status flops with a clear of all healed records at once
// depends on fcrt_pkg
`default_nettype none

module fcrt_status (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  fcrt_pkg::status_cmd_t         cmd_i,
  input  logic [fcrt_pkg::IDX_BITS-1:0] rd_idx_i,
  output fcrt_pkg::status_e             rd_status_o,
  output logic                          any_active_next_o
);
  import fcrt_pkg::*;

  status_e status_q [TABLE_DEPTH];
  status_e status_d [TABLE_DEPTH];

  always_comb begin
    any_active_next_o = 1'b0;
    for (int i = 0; i < int'(TABLE_DEPTH); i++) begin
      status_d[i] = status_q[i];
      if (cmd_i.clear_healed && status_q[i] == STAT_HEALED) begin
        status_d[i] = STAT_ABSENT;
      end
      if (cmd_i.wr && cmd_i.idx == IDX_BITS'(i)) begin
        status_d[i] = cmd_i.status;
      end
      any_active_next_o = any_active_next_o | (status_d[i] == STAT_ACTIVE);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < int'(TABLE_DEPTH); i++) begin
        status_q[i] <= STAT_ABSENT;
      end
    end else begin
      for (int i = 0; i < int'(TABLE_DEPTH); i++) begin
        status_q[i] <= status_d[i];
      end
    end
  end

  assign rd_status_o = status_q[rd_idx_i];

endmodule

`default_nettype wire

/* rtl/fcrt_checker.sv */
// port-level checker for the fault record table, bound to the top level
// depends on fcrt_pkg and fault_code_record_table_core_assert.svh
`default_nettype none

module fcrt_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              s_axis_tvalid,
  input logic                              s_axis_tready,
  input logic                              m_axis_tvalid,
  input logic                              m_axis_tready,
  input logic [fcrt_pkg::M_TDATA_BITS-1:0] m_axis_tdata
);
  import fcrt_pkg::*;

  `include "fault_code_record_table_core_assert.svh"

  logic [1:0] out_status;
  logic       out_req, out_act, out_rec_zero;

  assign out_status   = m_axis_tdata[OUT_STATUS_LSB +: 2];
  assign out_req      = m_axis_tdata[OUT_REQ_BIT];
  assign out_act      = m_axis_tdata[OUT_ACT_BIT];
  assign out_rec_zero = (m_axis_tdata[OUT_LAST_LSB - 1 + TIME_BITS:OUT_COUNT_LSB] == '0);

  // a stalled item keeps its payload
  `FCRT_ASSERT(a_out_hold, (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))

  // one item at a time: no accept right after an accept
  `FCRT_ASSERT(a_no_b2b, (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)

  // a safe-state request only comes with an active record
  `FCRT_ASSERT(a_req_active, (m_axis_tvalid && out_req) |-> (out_status == STAT_ACTIVE))

  // an active record implies the any-active flag
  `FCRT_ASSERT(a_any_active, (m_axis_tvalid && out_status == STAT_ACTIVE) |-> out_act)

  // an absent record shows zero count and times
  `FCRT_ASSERT(a_absent_zero, (m_axis_tvalid && out_status == STAT_ABSENT) |-> out_rec_zero)

endmodule

bind fault_code_record_table_core fcrt_checker u_fcrt_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

/* bench/fault_code_record_table_core_test.sv */
// testbench for the fault record table: directed, safe-state, backpressure and random tests
// depends on fcrt_pkg and fault_code_record_table_core; a built-in predictor checks each item
`default_nettype none

module fault_code_record_table_core_test;
  import fcrt_pkg::*;

  typedef struct {
    logic [CODE_BITS-1:0] code;
    status_e              status;
    logic [OCC_BITS-1:0]  count;
    logic [TIME_BITS-1:0] first_us;
    logic [TIME_BITS-1:0] last_us;
    logic                 req;
    logic                 act;
  } fault_record_t;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     s_axis_tvalid = 1'b0;
  logic                     s_axis_tready;
  // fields from bit 0: fault_code[3:0], time_us[67:4], zero pad
  logic [S_TDATA_BITS-1:0]  s_axis_tdata = '0;
  // fields from bit 0: kind[1:0]
  logic [S_TUSER_BITS-1:0]  s_axis_tuser = '0;
  logic                     m_axis_tvalid;
  logic                     m_axis_tready = 1'b0;
  // fields from bit 0: code_echo, record_status, occur_count,
  //   first_time_us, last_time_us, safe_state_request, any_active
  logic [M_TDATA_BITS-1:0]  m_axis_tdata;
  logic                     cfg_we_i = 1'b0;
  logic [CFG_IDX_BITS-1:0]  cfg_idx_i = '0;
  logic [CFG_DATA_BITS-1:0] cfg_wdata_i = '0;

  fault_code_record_table_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  // predicted record table and registers
  status_e              tbl_status [NUM_CODES];
  logic [OCC_BITS-1:0]  tbl_count  [NUM_CODES];
  logic [TIME_BITS-1:0] tbl_first  [NUM_CODES];
  logic [TIME_BITS-1:0] tbl_last   [NUM_CODES];
  logic [15:0]          fatal_bits = FATAL_MASK_RST;
  logic                 safe_on = 1'b0;

  fault_record_t        pending_records [$];
  int                   error_count = 0;
  logic [TIME_BITS-1:0] clock_us = '0;
  logic                 calm = 1'b0;
  int                   stall_req = 0;
  int                   stall_done = 0;
  int                   stall_left = 0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #3_000_000;
    $display("** fault_code_record_table_core: FAILED **");
    $finish;
  end

  initial begin
    for (int i = 0; i < NUM_CODES; i++) begin
      tbl_status[i] = STAT_ABSENT;
      tbl_count[i]  = '0;
      tbl_first[i]  = '0;
      tbl_last[i]   = '0;
    end
  end

  function automatic fault_record_t apply_fault_item(kind_e kind, logic [CODE_BITS-1:0] code,
                                                     logic [TIME_BITS-1:0] now);
    fault_record_t r;
    r.req = 1'b0;
    case (kind)
      KIND_REPORT: begin
        if (tbl_status[code] == STAT_ABSENT) begin
          tbl_count[code] = OCC_BITS'(1);
          tbl_first[code] = now;
        end else if (tbl_count[code] != '1) begin
          tbl_count[code] = tbl_count[code] + OCC_BITS'(1);
        end
        tbl_status[code] = STAT_ACTIVE;
        tbl_last[code]   = now;
        r.req = fatal_bits[code] & safe_on;
      end
      KIND_HEAL: begin
        if (tbl_status[code] == STAT_ACTIVE) tbl_status[code] = STAT_HEALED;
      end
      KIND_CLEAR: begin
        for (int i = 0; i < NUM_CODES; i++) begin
          if (tbl_status[i] != STAT_ACTIVE) begin
            tbl_status[i] = STAT_ABSENT;
            tbl_count[i]  = '0;
            tbl_first[i]  = '0;
            tbl_last[i]   = '0;
          end
        end
      end
      default: ;
    endcase
    r.code     = code;
    r.status   = tbl_status[code];
    r.count    = tbl_count[code];
    r.first_us = tbl_first[code];
    r.last_us  = tbl_last[code];
    r.act      = 1'b0;
    for (int i = 0; i < NUM_CODES; i++) begin
      if (tbl_status[i] == STAT_ACTIVE) r.act = 1'b1;
    end
    return r;
  endfunction

  function automatic void check_field(string fld, logic [63:0] exp_v, logic [63:0] got_v);
    if (exp_v !== got_v) begin
      $error("%s: expected %0h, got %0h", fld, exp_v, got_v);
      error_count++;
    end
  endfunction

  // result side: random stalls, plus a long hold-off on request
  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      stall_left = stall_left - 1;
      m_axis_tready <= 1'b0;
    end else if (stall_req != stall_done) begin
      stall_done = stall_req;
      stall_left = 80;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= calm || ($urandom_range(99) >= 14);
    end
  end

  always @(posedge clk_i) begin
    fault_record_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_records.size() == 0) begin
        $error("record output with no item waiting for it");
        error_count++;
      end else begin
        want = pending_records.pop_front();
        check_field("code_echo", 64'(want.code),
                    64'(m_axis_tdata[OUT_CODE_LSB +: CODE_BITS]));
        check_field("record_status", 64'(want.status),
                    64'(m_axis_tdata[OUT_STATUS_LSB +: 2]));
        check_field("occur_count", 64'(want.count),
                    64'(m_axis_tdata[OUT_COUNT_LSB +: OCC_BITS]));
        check_field("first_time_us", want.first_us, m_axis_tdata[OUT_FIRST_LSB +: TIME_BITS]);
        check_field("last_time_us", want.last_us, m_axis_tdata[OUT_LAST_LSB +: TIME_BITS]);
        check_field("safe_state_request", 64'(want.req), 64'(m_axis_tdata[OUT_REQ_BIT]));
        check_field("any_active", 64'(want.act), 64'(m_axis_tdata[OUT_ACT_BIT]));
      end
    end
  end

  task automatic send_item(kind_e kind, logic [CODE_BITS-1:0] code, logic [TIME_BITS-1:0] now);
    if (!calm && $urandom_range(99) < 14) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'b0, now, code};
    s_axis_tuser  <= kind;
    do @(posedge clk_i); while (!s_axis_tready);
    pending_records.insert(pending_records.size(), apply_fault_item(kind, code, now));
  endtask

  // drop valid and wait for every outstanding record
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (pending_records.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [15:0] val);
    settle();
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_FATAL_MASK) fatal_bits = val;
    else safe_on = val[0];
  endtask

  // mostly increasing time, now and then a fully random stamp
  function automatic logic [TIME_BITS-1:0] next_time();
    if ($urandom_range(19) == 0) clock_us = {$urandom, $urandom};
    else clock_us = clock_us + $urandom_range(5000, 1);
    return clock_us;
  endfunction

  task automatic test_directed_records();
    send_item(KIND_READ, 4'd0, 64'd0);
    send_item(KIND_READ, 4'd15, '1);
    send_item(KIND_REPORT, 4'd0, 64'd0);
    send_item(KIND_REPORT, 4'd15, '1);
    // re-report keeps the first stamp
    send_item(KIND_REPORT, 4'd15, 64'h5555_5555_5555_5555);
    send_item(KIND_HEAL, 4'd15, 64'd0);
    send_item(KIND_HEAL, 4'd15, 64'd0);
    send_item(KIND_HEAL, 4'd3, 64'd0);
    // fatal code while safe state is still off
    send_item(KIND_REPORT, 4'd6, 64'hAAAA_AAAA_AAAA_AAAA);
    send_item(KIND_REPORT, 4'd15, 64'd1);
    send_item(KIND_HEAL, 4'd15, 64'd0);
    send_item(KIND_CLEAR, 4'd15, 64'd0);
    send_item(KIND_READ, 4'd0, '1);
    send_item(KIND_HEAL, 4'd0, 64'd0);
    send_item(KIND_HEAL, 4'd6, 64'd0);
    send_item(KIND_READ, 4'd6, 64'd0);
    send_item(KIND_CLEAR, 4'd9, '1);
    send_item(KIND_READ, 4'd0, 64'd0);
    send_item(KIND_REPORT, 4'd15, 64'd7);
    settle();
  endtask

  task automatic test_safe_state_request();
    write_reg(CFG_SAFE_EN, 16'd1);
    send_item(KIND_REPORT, 4'd6, next_time());
    send_item(KIND_REPORT, 4'd10, next_time());
    send_item(KIND_REPORT, 4'd11, next_time());
    send_item(KIND_REPORT, 4'd0, next_time());
    send_item(KIND_CLEAR, 4'd6, next_time());
    write_reg(CFG_FATAL_MASK, 16'hFFFF);
    repeat (12) send_item(KIND_REPORT, 4'($urandom_range(15)), next_time());
    write_reg(CFG_FATAL_MASK, 16'h0000);
    repeat (12) send_item(KIND_REPORT, 4'($urandom_range(15)), next_time());
    write_reg(CFG_FATAL_MASK, 16'($urandom));
    write_reg(CFG_SAFE_EN, 16'd0);
    repeat (12) send_item(KIND_REPORT, 4'($urandom_range(15)), next_time());
    settle();
  endtask

  task automatic test_output_backpressure();
    write_reg(CFG_SAFE_EN, 16'd1);
    calm = 1'b1;
    stall_req++;
    repeat (24) begin
      send_item($urandom_range(1) ? KIND_REPORT : KIND_READ, 4'($urandom_range(15)),
                next_time());
    end
    calm = 1'b0;
    settle();
  endtask

  task automatic test_random_traffic();
    kind_e kind;
    int    roll;
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          write_reg(CFG_FATAL_MASK, 16'hFFFF);
          write_reg(CFG_SAFE_EN, 16'd1);
        end
        1: write_reg(CFG_FATAL_MASK, 16'h0000);
        2: write_reg(CFG_FATAL_MASK, 16'($urandom));
        default: begin
          write_reg(CFG_FATAL_MASK, 16'($urandom));
          write_reg(CFG_SAFE_EN, 16'd0);
        end
      endcase
      for (int n = 0; n < 160; n++) begin
        // a long stretch with no idling on either side
        calm = (ph == 1) && (n >= 40) && (n < 140);
        roll = $urandom_range(99);
        if (roll < 45) kind = KIND_REPORT;
        else if (roll < 65) kind = KIND_HEAL;
        else if (roll < 73) kind = KIND_CLEAR;
        else kind = KIND_READ;
        send_item(kind, 4'($urandom_range(15)), next_time());
      end
      calm = 1'b0;
    end
    settle();
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_records();
    test_safe_state_request();
    test_output_backpressure();
    test_random_traffic();
    settle();
    repeat (10) @(posedge clk_i);
    if (error_count == 0) begin
      $display("** fault_code_record_table_core: PASSED **");
    end else begin
      $display("** fault_code_record_table_core: FAILED **");
    end
    $finish;
  end

endmodule

`default_nettype wire
